FILE: rtl/tde_pkg.sv
// Shared types and constants for the TLV record scanner.
// Beat structs, parse phase and status codes; no dependencies.
package tde_pkg;

    // Bytes at or above this position are not parsed (range 7 .. 65535).
    localparam int MAX_PAYLOAD_BYTES = 1024;
    // Leading bytes skipped before the first record (range 0 .. 16).
    localparam int HEADER_SKIP = 2;
    // Shorter payloads always report not found.
    localparam int MIN_PAYLOAD_BYTES = 7;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_ID      = 3'd1,
        PH_TYPE    = 3'd2,
        PH_SIZE_HI = 3'd3,
        PH_SIZE_LO = 3'd4,
        PH_VALUE   = 3'd5,
        PH_SKIP    = 3'd6,
        PH_DONE    = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_NOT_FOUND = 2'd0,
        ST_FOUND     = 2'd1,
        ST_BAD_SIZE  = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       end_of_payload;
        logic [7:0] wanted_id;
    } in_beat_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  record_type;
        logic [15:0] record_size;
        logic [31:0] record_value;
    } out_beat_t;

endpackage

FILE: rtl/tde_in_reg.sv
// Input register stage of the TLV record scanner.
// Holds one accepted beat until the parser takes it; uses tde_pkg.
module tde_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tde_pkg::in_beat_t s_data,
    output logic              q_valid,
    output tde_pkg::in_beat_t q_data,
    input  logic              q_take
);

    logic              valid_reg;
    logic              valid_next;
    tde_pkg::in_beat_t data_reg;

    assign s_ready = !valid_reg || q_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;

endmodule

FILE: rtl/tde_parser.sv
// Record walker of the TLV record scanner: parse phase, counters and capture.
// Updates once per taken beat and forms the result on the last byte; uses tde_pkg.
module tde_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               take,
    input  tde_pkg::in_beat_t  beat,
    output logic               res_valid,
    output tde_pkg::out_beat_t res_data
);

    tde_pkg::phase_t  phase_reg, phase_next, ph_parsed, eff_phase;
    tde_pkg::status_t status_reg, status_next, status_p, st_out;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] rem_reg, rem_next, rem_p;
    logic        match_reg, match_next, match_p;
    logic [7:0]  type_reg, type_next, type_p;
    logic [15:0] size_reg, size_next, size_p;
    logic [31:0] acc_reg, acc_next, acc_p;

    logic        parse_en;
    logic [15:0] size_word;
    logic [15:0] rem_dec;
    logic        size_ok;
    logic        long_enough;

    assign parse_en  = pos_reg < 16'(tde_pkg::MAX_PAYLOAD_BYTES);
    assign size_word = {rem_reg[15:8], beat.payload_byte};
    assign rem_dec   = rem_reg - 16'd1;
    assign size_ok   = (size_word == 16'd1) || (size_word == 16'd2) || (size_word == 16'd4);
    // kept count is min(pos + 1, MAX) and MAX is never below the minimum
    assign long_enough = pos_reg >= 16'(tde_pkg::MIN_PAYLOAD_BYTES - 1);

    // Header falls through to the id byte in the same beat once skipped.
    always_comb begin
        eff_phase = phase_reg;
        if (phase_reg == tde_pkg::PH_HEADER && pos_reg >= 16'(tde_pkg::HEADER_SKIP)) begin
            eff_phase = tde_pkg::PH_ID;
        end
    end

    // Next phase for one parsed byte
    always_comb begin
        ph_parsed = phase_reg;
        if (parse_en) begin
            unique case (eff_phase)
                tde_pkg::PH_HEADER:  ph_parsed = tde_pkg::PH_HEADER;
                tde_pkg::PH_ID:      ph_parsed = tde_pkg::PH_TYPE;
                tde_pkg::PH_TYPE:    ph_parsed = tde_pkg::PH_SIZE_HI;
                tde_pkg::PH_SIZE_HI: ph_parsed = tde_pkg::PH_SIZE_LO;
                tde_pkg::PH_SIZE_LO: begin
                    if (match_reg) begin
                        ph_parsed = size_ok ? tde_pkg::PH_VALUE : tde_pkg::PH_DONE;
                    end else begin
                        ph_parsed = (size_word == 16'd0) ? tde_pkg::PH_ID : tde_pkg::PH_SKIP;
                    end
                end
                tde_pkg::PH_VALUE: begin
                    ph_parsed = (rem_dec == 16'd0) ? tde_pkg::PH_DONE : tde_pkg::PH_VALUE;
                end
                tde_pkg::PH_SKIP: begin
                    ph_parsed = (rem_dec == 16'd0) ? tde_pkg::PH_ID : tde_pkg::PH_SKIP;
                end
                tde_pkg::PH_DONE:    ph_parsed = tde_pkg::PH_DONE;
                default:             ph_parsed = phase_reg;
            endcase
        end
    end

    // Counters and capture for one parsed byte
    always_comb begin
        match_p  = match_reg;
        type_p   = type_reg;
        size_p   = size_reg;
        rem_p    = rem_reg;
        acc_p    = acc_reg;
        status_p = status_reg;
        if (parse_en) begin
            case (eff_phase)
                tde_pkg::PH_ID: begin
                    match_p = beat.payload_byte == beat.wanted_id;
                end
                tde_pkg::PH_TYPE: begin
                    if (match_reg) begin
                        type_p = beat.payload_byte;
                    end
                end
                tde_pkg::PH_SIZE_HI: begin
                    rem_p = {beat.payload_byte, 8'h00};
                    if (match_reg) begin
                        size_p = {beat.payload_byte, 8'h00};
                    end
                end
                tde_pkg::PH_SIZE_LO: begin
                    rem_p = size_word;
                    if (match_reg) begin
                        size_p = size_word;
                        if (size_ok) begin
                            acc_p = 32'd0;
                        end else begin
                            status_p = tde_pkg::ST_BAD_SIZE;
                        end
                    end
                end
                tde_pkg::PH_VALUE: begin
                    acc_p = {acc_reg[23:0], beat.payload_byte};
                    rem_p = rem_dec;
                    if (rem_dec == 16'd0) begin
                        status_p = tde_pkg::ST_FOUND;
                    end
                end
                tde_pkg::PH_SKIP: begin
                    rem_p = rem_dec;
                end
                default: begin
                end
            endcase
        end
    end

    // Result from the state as it stands after the last byte
    always_comb begin
        case (ph_parsed) inside
            tde_pkg::PH_DONE: st_out = status_p;
            tde_pkg::PH_TYPE, tde_pkg::PH_SIZE_HI, tde_pkg::PH_SIZE_LO,
            tde_pkg::PH_VALUE: st_out = tde_pkg::ST_TRUNCATED;
            default: st_out = tde_pkg::ST_NOT_FOUND;
        endcase
        if (!long_enough) begin
            st_out = tde_pkg::ST_NOT_FOUND;
        end
        res_data.status       = st_out;
        res_data.record_type  = 8'd0;
        res_data.record_size  = 16'd0;
        res_data.record_value = 32'd0;
        if (st_out != tde_pkg::ST_NOT_FOUND && match_p) begin
            res_data.record_type = type_p;
            res_data.record_size = size_p;
        end
        if (st_out == tde_pkg::ST_FOUND) begin
            res_data.record_value = acc_p;
        end
    end

    assign res_valid = take && beat.end_of_payload;

    // Last byte returns everything to the reset state for the next payload
    always_comb begin
        phase_next  = phase_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        match_next  = match_reg;
        type_next   = type_reg;
        size_next   = size_reg;
        acc_next    = acc_reg;
        if (take) begin
            if (beat.end_of_payload) begin
                phase_next  = tde_pkg::PH_HEADER;
                status_next = tde_pkg::ST_NOT_FOUND;
                pos_next    = 16'd0;
                rem_next    = 16'd0;
                match_next  = 1'b0;
                type_next   = 8'd0;
                size_next   = 16'd0;
                acc_next    = 32'd0;
            end else begin
                phase_next  = ph_parsed;
                status_next = status_p;
                pos_next    = (pos_reg == 16'hFFFF) ? pos_reg : pos_reg + 16'd1;
                rem_next    = rem_p;
                match_next  = match_p;
                type_next   = type_p;
                size_next   = size_p;
                acc_next    = acc_p;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= tde_pkg::PH_HEADER;
            status_reg <= tde_pkg::ST_NOT_FOUND;
            pos_reg    <= 16'd0;
            rem_reg    <= 16'd0;
            match_reg  <= 1'b0;
            type_reg   <= 8'd0;
            size_reg   <= 16'd0;
            acc_reg    <= 32'd0;
        end else begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            pos_reg    <= pos_next;
            rem_reg    <= rem_next;
            match_reg  <= match_next;
            type_reg   <= type_next;
            size_reg   <= size_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

FILE: rtl/tde_out_reg.sv
// Result register of the TLV record scanner.
// Holds one result beat until the consumer takes it; uses tde_pkg.
module tde_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  tde_pkg::out_beat_t load_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tde_pkg::out_beat_t m_data
);

    logic               valid_reg;
    logic               valid_next;
    tde_pkg::out_beat_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

FILE: rtl/tlv_datapoint_extractor.sv
// Top level of the TLV record scanner: input register, record walker, result register.
// Depends on tde_pkg, tde_in_reg, tde_parser and tde_out_reg.
//
//  channel | ports                     | beat
//  --------+---------------------------+------------------------------------------
//  input   | s_valid s_ready s_data    | one payload byte, last marker, wanted id
//  result  | m_valid m_ready m_data    | status, type, size, value; one per payload
//
// One payload byte per cycle, unless a held result stalls the last byte of a payload.
// A result is registered in the result register when the walker takes its last byte.
// aresetn is synchronous and clears both valid bits and the walker state.
// A result held by the consumer stalls the input only once the last byte of the
// next payload reaches the walker; the earlier bytes of that payload keep flowing.
module tlv_datapoint_extractor (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tde_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tde_pkg::out_beat_t m_data
);

    logic               q_valid;
    tde_pkg::in_beat_t  q_data;
    logic               q_take;
    logic               res_valid;
    tde_pkg::out_beat_t res_data;

    // Advance unless this beat makes a result and the result slot is still held
    assign q_take = q_valid && (!q_data.end_of_payload || !m_valid || m_ready);

    tde_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_take  (q_take)
    );

    tde_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (q_take),
        .beat      (q_data),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    tde_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_data (res_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: tb/tlv_datapoint_extractor_tb.sv
// Testbench for tlv_datapoint_extractor: directed and random payloads with idle gaps and stalls.
// A scoreboard class predicts one report per payload and checks every result beat.
// Depends on tde_pkg and the tlv_datapoint_extractor RTL.
`timescale 1ns / 100ps

module tlv_datapoint_extractor_tb;

    class tlv_scoreboard;
        logic [15:0]          pos;
        tde_pkg::phase_t      ph;
        logic [15:0]          left;
        bit                   hit;
        logic [7:0]           cap_type;
        logic [15:0]          cap_size;
        logic [31:0]          acc;
        tde_pkg::status_t     verdict;
        tde_pkg::out_beat_t   pending_reports[$];
        int                   errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            pos      = '0;
            ph       = tde_pkg::PH_HEADER;
            left     = '0;
            hit      = 1'b0;
            cap_type = '0;
            cap_size = '0;
            acc      = '0;
            verdict  = tde_pkg::ST_NOT_FOUND;
        endfunction

        // Advance the record walker by one accepted byte; queue a report on the last one.
        function void note_byte(tde_pkg::in_beat_t d);
            int                 kept;
            tde_pkg::out_beat_t r;
            if (pos < tde_pkg::MAX_PAYLOAD_BYTES) begin
                if (ph == tde_pkg::PH_HEADER && pos >= tde_pkg::HEADER_SKIP) ph = tde_pkg::PH_ID;
                case (ph)
                    tde_pkg::PH_ID: begin
                        hit = (d.payload_byte == d.wanted_id);
                        ph = tde_pkg::PH_TYPE;
                    end
                    tde_pkg::PH_TYPE: begin
                        if (hit) cap_type = d.payload_byte;
                        ph = tde_pkg::PH_SIZE_HI;
                    end
                    tde_pkg::PH_SIZE_HI: begin
                        left = {d.payload_byte, 8'h00};
                        if (hit) cap_size = left;
                        ph = tde_pkg::PH_SIZE_LO;
                    end
                    tde_pkg::PH_SIZE_LO: begin
                        left = left | {8'h00, d.payload_byte};
                        if (hit) begin
                            cap_size = left;
                            if (left == 16'd1 || left == 16'd2 || left == 16'd4) begin
                                acc = '0;
                                ph = tde_pkg::PH_VALUE;
                            end else begin
                                verdict = tde_pkg::ST_BAD_SIZE;
                                ph = tde_pkg::PH_DONE;
                            end
                        end else if (left == 16'd0) begin
                            ph = tde_pkg::PH_ID;
                        end else begin
                            ph = tde_pkg::PH_SKIP;
                        end
                    end
                    tde_pkg::PH_VALUE: begin
                        acc = {acc[23:0], d.payload_byte};
                        left--;
                        if (left == 16'd0) begin
                            verdict = tde_pkg::ST_FOUND;
                            ph = tde_pkg::PH_DONE;
                        end
                    end
                    tde_pkg::PH_SKIP: begin
                        left--;
                        if (left == 16'd0) ph = tde_pkg::PH_ID;
                    end
                    default: ;
                endcase
            end
            if (!d.end_of_payload) begin
                if (pos != 16'hFFFF) pos++;
                return;
            end
            kept = int'(pos) + 1;
            if (kept > tde_pkg::MAX_PAYLOAD_BYTES) kept = tde_pkg::MAX_PAYLOAD_BYTES;
            r = '0;
            r.status = tde_pkg::ST_NOT_FOUND;
            if (kept >= tde_pkg::MIN_PAYLOAD_BYTES) begin
                case (ph) inside
                    tde_pkg::PH_DONE: r.status = verdict;
                    tde_pkg::PH_TYPE, tde_pkg::PH_SIZE_HI, tde_pkg::PH_SIZE_LO,
                    tde_pkg::PH_VALUE: r.status = tde_pkg::ST_TRUNCATED;
                    default: r.status = tde_pkg::ST_NOT_FOUND;
                endcase
                if (r.status != tde_pkg::ST_NOT_FOUND && hit) begin
                    r.record_type = cap_type;
                    r.record_size = cap_size;
                end
                if (r.status == tde_pkg::ST_FOUND) r.record_value = acc;
            end
            pending_reports.push_back(r);
            restart();
        endfunction

        function void check_result(tde_pkg::out_beat_t got);
            tde_pkg::out_beat_t w;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report: status %0d type %02h size %04h value %08h",
                         $time, got.status, got.record_type, got.record_size, got.record_value);
                errors++;
                return;
            end
            w = pending_reports.pop_front();
            if (got.status !== w.status) begin
                $display("%0t: status expected %0d got %0d", $time, w.status, got.status);
                errors++;
            end
            if (got.record_type !== w.record_type) begin
                $display("%0t: record_type expected %02h got %02h",
                         $time, w.record_type, got.record_type);
                errors++;
            end
            if (got.record_size !== w.record_size) begin
                $display("%0t: record_size expected %04h got %04h",
                         $time, w.record_size, got.record_size);
                errors++;
            end
            if (got.record_value !== w.record_value) begin
                $display("%0t: record_value expected %08h got %08h",
                         $time, w.record_value, got.record_value);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    tde_pkg::in_beat_t   s_data;
    logic                m_valid;
    logic                m_ready;
    tde_pkg::out_beat_t  m_data;

    tlv_scoreboard sb = new();
    logic [7:0]    pl[$];
    bit            calm = 1'b0;
    int            items_sent = 0;

    tlv_datapoint_extractor dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic void add_noise(int n);
        repeat (n) pl.push_back(8'($urandom));
    endfunction

    function automatic void add_header();
        add_noise(tde_pkg::HEADER_SKIP);
    endfunction

    // Append one record; value bytes are v big-endian when nval <= 4, else random.
    function automatic void push_rec(logic [7:0] rid, logic [7:0] rtype, logic [15:0] rsize,
                                     int nval, logic [31:0] v);
        logic [31:0] sh;
        sh = (nval <= 4) ? (v << (8 * (4 - nval))) : 32'd0;
        pl.push_back(rid);
        pl.push_back(rtype);
        pl.push_back(rsize[15:8]);
        pl.push_back(rsize[7:0]);
        for (int i = 0; i < nval; i++) begin
            if (nval <= 4) begin
                pl.push_back(sh[31:24]);
                sh = sh << 8;
            end else begin
                pl.push_back(8'($urandom));
            end
        end
    endfunction

    task automatic send_payload(logic [7:0] id);
        tde_pkg::in_beat_t d;
        int                g;
        if (pl.size() == 0) pl.push_back(8'($urandom));
        foreach (pl[i]) begin
            g = gap_len();
            if (g > 0) begin
                s_valid <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            d.payload_byte   = pl[i];
            d.end_of_payload = (i == pl.size() - 1);
            d.wanted_id      = id;
            s_valid <= 1'b1;
            s_data  <= d;
            do @(posedge aclk); while (!s_ready);
            sb.note_byte(d);
            items_sent++;
        end
        pl.delete();
    endtask

    task automatic drain_reports();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_reports.size() != 0);
    endtask

    // Result side: check every accepted beat, stall at random.
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_result(m_data);
            if (hold_cnt > 0) begin
                m_ready <= 1'b0;
                hold_cnt--;
            end else begin
                m_ready <= 1'b1;
                hold_cnt = gap_len();
            end
        end
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [7:0]  id;
        logic [15:0] sz;
        int          nrec;
        int          nval;
        int          payloads;
        bit          match;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        m_ready <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Smallest payload that can report found, with all-ones fields.
        pl.push_back(8'hFF); pl.push_back(8'hFF);
        push_rec(8'hFF, 8'hFF, 16'd1, 1, 32'hFF);
        send_payload(8'hFF);
        add_header(); push_rec(8'h00, 8'h00, 16'd4, 4, 32'hFFFF_FFFF);
        send_payload(8'h00);
        // Skip a zero-size and a three-byte record, then match; a second match is ignored.
        add_header();
        push_rec(8'h11, 8'h01, 16'd0, 0, 0);
        push_rec(8'h12, 8'h02, 16'd3, 3, 32'h00AB_CDEF);
        push_rec(8'h10, 8'h5C, 16'd2, 2, 32'h0000_A55A);
        push_rec(8'h10, 8'h01, 16'd1, 1, 32'h7);
        send_payload(8'h10);
        // Unsupported sizes, with trailing bytes ignored.
        add_header(); push_rec(8'h20, 8'h33, 16'd0, 0, 0); add_noise(3);
        send_payload(8'h20);
        add_header(); push_rec(8'h21, 8'h44, 16'd3, 3, 32'h0012_3456);
        send_payload(8'h21);
        add_header(); push_rec(8'h22, 8'h55, 16'hFFFF, 0, 0); add_noise(5);
        send_payload(8'h22);
        add_header(); push_rec(8'h23, 8'h66, 16'h0100, 2, 32'h1234);
        send_payload(8'h23);
        // Too short to report, although a value was under way.
        add_header(); push_rec(8'h30, 8'h01, 16'd1, 0, 0);
        send_payload(8'h30);
        pl.push_back(8'h5A);
        send_payload(8'h5A);
        // Matched record cut after id, after type, after size high byte.
        add_header(); push_rec(8'h40, 8'h00, 16'd0, 0, 0); pl.push_back(8'h41);
        send_payload(8'h41);
        add_header(); push_rec(8'h40, 8'h00, 16'd0, 0, 0);
        pl.push_back(8'h41); pl.push_back(8'h9A);
        send_payload(8'h41);
        add_header(); push_rec(8'h40, 8'h00, 16'd0, 0, 0);
        pl.push_back(8'h41); pl.push_back(8'h9A); pl.push_back(8'h01);
        send_payload(8'h41);
        // Other record cut inside its header.
        add_header(); push_rec(8'h40, 8'h00, 16'd0, 0, 0);
        pl.push_back(8'h50); pl.push_back(8'h51);
        send_payload(8'h52);
        // Matched value cut, skipped value cut, payload ending on a record boundary.
        add_header(); push_rec(8'h60, 8'h06, 16'd4, 2, 32'hBEEF);
        send_payload(8'h60);
        add_header(); push_rec(8'h70, 8'h07, 16'd10, 3, 32'h0001_0203);
        send_payload(8'h71);
        add_header(); push_rec(8'h70, 8'h07, 16'd2, 2, 32'h0102);
        send_payload(8'h71);
        drain_reports();

        // Long payload: matched header straddles the parse limit.
        calm = 1'b1;
        add_header();
        repeat (51) push_rec(8'h81, 8'h00, 16'd16, 16, 0);
        push_rec(8'h80, 8'h01, 16'd4, 4, 32'h0100_0000);
        add_noise(70);
        send_payload(8'h80);
        calm = 1'b0;

        items_sent = 0;
        payloads = 0;
        while (items_sent < 550) begin
            calm = ($urandom_range(0, 5) == 0);
            if (payloads % 12 == 5) drain_reports();
            id = 8'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                add_noise($urandom_range(1, 12));
            end else begin
                add_header();
                nrec = $urandom_range(0, 4);
                for (int r = 0; r < nrec; r++) begin
                    match = ($urandom_range(0, 2) == 0);
                    if (match) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2: sz = 16'd1;
                            3, 4, 5: sz = 16'd2;
                            6, 7:    sz = 16'd4;
                            8:       sz = 16'($urandom_range(0, 8));
                            default: sz = 16'($urandom);
                        endcase
                    end else begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4, 5, 6: sz = 16'($urandom_range(0, 6));
                            7, 8:                sz = 16'($urandom_range(7, 40));
                            default:             sz = 16'($urandom);
                        endcase
                    end
                    nval = (sz > 40) ? $urandom_range(0, 8) : int'(sz);
                    push_rec(match ? id : id ^ 8'($urandom_range(1, 255)), 8'($urandom), sz,
                             nval, $urandom);
                    // A huge size ends the payload inside the value.
                    if (sz > 40) break;
                end
                if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 6));
                if ($urandom_range(0, 3) == 0 && pl.size() > 1)
                    pl = pl[0:$urandom_range(0, pl.size() - 2)];
            end
            send_payload(id);
            payloads++;
        end

        drain_reports();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
